// ===== sv/pga_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the point gravity accumulator.
package pga_pkg;

  // configuration register index (byte address bit 2)
  localparam logic REG_COUNT = 1'b0;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // shared divider: 56-bit dividend, 50-bit divisor
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 50;

  localparam logic [49:0] I_MAX = {50{1'b1}};

  typedef struct packed {
    logic              opcode;
    logic [3:0]        slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]       strength;
    logic signed [47:0] accel_in_x;
    logic signed [47:0] accel_in_y;
    logic signed [47:0] accel_in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] accel_out_x;
    logic signed [47:0] accel_out_y;
    logic signed [47:0] accel_out_z;
    logic              coincident;
    logic              saturated;
  } out_item_t;

  // signed pull of one attractor, status flags
  typedef struct packed {
    logic signed [51:0] cx;
    logic signed [51:0] cy;
    logic signed [51:0] cz;
    logic              skip;
    logic              sat;
  } pull_t;

endpackage

// ===== sv/pga_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pga_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pga_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module pga_div
  import pga_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] qn_r, qn_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW:0]   trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, qn_r[DIV_NW-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    qn_nxt   = qn_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      qn_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      qn_nxt  = {qn_r[DIV_NW-2:0], ge};
      rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = qn_r;

endmodule

// ===== sv/pga_pair.sv =====
`timescale 1ns / 1ps
// Sequencer for the pull of one attractor on one body.
module pga_pair
  import pga_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        att_x,
  input  logic [31:0]        att_y,
  input  logic [31:0]        att_z,
  input  logic [31:0]        att_str,
  input  logic signed [31:0] body_x,
  input  logic signed [31:0] body_y,
  input  logic signed [31:0] body_z,
  output logic               done,
  output pull_t              pull
);

  localparam logic [3:0] P_IDLE    = 4'd0;
  localparam logic [3:0] P_SHIFT   = 4'd1;
  localparam logic [3:0] P_SQ      = 4'd2;
  localparam logic [3:0] P_SQRT0   = 4'd3;
  localparam logic [3:0] P_SQRT    = 4'd4;
  localparam logic [3:0] P_IDIV_GO = 4'd5;
  localparam logic [3:0] P_IDIV    = 4'd6;
  localparam logic [3:0] P_UDIV_GO = 4'd7;
  localparam logic [3:0] P_UDIV    = 4'd8;
  localparam logic [3:0] P_MLO     = 4'd9;
  localparam logic [3:0] P_MHI     = 4'd10;
  localparam logic [3:0] P_COMB    = 4'd11;
  localparam logic [3:0] P_DONE    = 4'd12;

  function automatic logic [3:0] shift_for(input logic [32:0] v);
    logic [3:0] s;
    s = '0;
    for (int j = 1; j <= 9; j++) begin
      if (v[23+j]) s = 4'(j);
    end
    return s;
  endfunction

  logic [3:0]        state_r, state_nxt;
  logic [2:0][32:0]  mag_r, mag_nxt;
  logic [2:0]        neg_r, neg_nxt;
  logic [31:0]       str_r, str_nxt;
  logic [2:0][23:0]  e_r, e_nxt;
  logic [3:0]        s_r, s_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [49:0]       q_r, q_nxt;
  logic [49:0]       n_r, n_nxt;
  logic [50:0]       res_r, res_nxt;
  logic [48:0]       bit_r, bit_nxt;
  logic [4:0]        sq_cnt_r, sq_cnt_nxt;
  logic [25:0]       r_r, r_nxt;
  logic [49:0]       inten_r, inten_nxt;
  logic [30:0]       u_r, u_nxt;
  logic [54:0]       plo_r, plo_nxt;
  logic [56:0]       phi_r, phi_nxt;
  logic [2:0][51:0]  contrib_r, contrib_nxt;
  logic              skip_r, skip_nxt;
  logic              sat_r, sat_nxt;

  logic [2:0][32:0]  dif;
  logic [32:0]       orv;
  logic [3:0]        s_calc;
  logic [47:0]       sq;
  logic [50:0]       sq_t;
  logic [DIV_NW-1:0] shq;
  logic [80:0]       prod;
  logic [50:0]       c;
  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;

  pga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    dif[0] = {att_x[31], att_x} - {body_x[31], body_x};
    dif[1] = {att_y[31], att_y} - {body_y[31], body_y};
    dif[2] = {att_z[31], att_z} - {body_z[31], body_z};
    orv    = mag_r[0] | mag_r[1] | mag_r[2];
    s_calc = shift_for(orv);
    sq     = e_r[k_r] * e_r[k_r];
    sq_t   = res_r + {2'b00, bit_r};
    shq    = div_quo >> {s_r, 1'b0};
    prod   = {phi_r, 24'd0} + 81'(plo_r);
    c      = prod[80:30];

    div_start = (state_r == P_IDIV_GO) || (state_r == P_UDIV_GO);
    div_num   = (state_r == P_IDIV_GO) ? {str_r, 24'd0} : {2'b00, e_r[k_r], 30'd0};
    div_den   = (state_r == P_IDIV_GO) ? q_r : {24'd0, r_r};

    state_nxt   = state_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    str_nxt     = str_r;
    e_nxt       = e_r;
    s_nxt       = s_r;
    k_nxt       = k_r;
    q_nxt       = q_r;
    n_nxt       = n_r;
    res_nxt     = res_r;
    bit_nxt     = bit_r;
    sq_cnt_nxt  = sq_cnt_r;
    r_nxt       = r_r;
    inten_nxt   = inten_r;
    u_nxt       = u_r;
    plo_nxt     = plo_r;
    phi_nxt     = phi_r;
    contrib_nxt = contrib_r;
    skip_nxt    = skip_r;
    sat_nxt     = sat_r;

    case (state_r)
      P_IDLE: begin
        if (start) begin
          for (int k = 0; k < 3; k++) begin
            neg_nxt[k] = dif[k][32];
            mag_nxt[k] = dif[k][32] ? 33'(-dif[k]) : dif[k];
          end
          str_nxt   = att_str;
          skip_nxt  = 1'b0;
          sat_nxt   = 1'b0;
          state_nxt = P_SHIFT;
        end
      end
      P_SHIFT: begin
        if (orv == '0) begin
          // attractor on top of the body: no pull
          skip_nxt    = 1'b1;
          contrib_nxt = '0;
          state_nxt   = P_DONE;
        end else begin
          s_nxt = s_calc;
          for (int k = 0; k < 3; k++) begin
            e_nxt[k] = 24'(mag_r[k] >> s_calc);
          end
          k_nxt     = '0;
          q_nxt     = '0;
          state_nxt = P_SQ;
        end
      end
      P_SQ: begin
        q_nxt = q_r + 50'(sq);
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          state_nxt = P_SQRT0;
        end
      end
      P_SQRT0: begin
        n_nxt      = q_r;
        res_nxt    = '0;
        bit_nxt    = 49'd1 << 48;
        sq_cnt_nxt = '0;
        state_nxt  = P_SQRT;
      end
      P_SQRT: begin
        if ({1'b0, n_r} >= sq_t) begin
          n_nxt   = n_r - sq_t[49:0];
          res_nxt = (res_r >> 1) + {2'b00, bit_r};
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt    = bit_r >> 2;
        sq_cnt_nxt = sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'd24) begin
          state_nxt = P_IDIV_GO;
        end
      end
      P_IDIV_GO: begin
        r_nxt     = res_r[25:0];
        state_nxt = P_IDIV;
      end
      P_IDIV: begin
        if (div_done) begin
          if (shq[DIV_NW-1:50] != '0) begin
            inten_nxt = I_MAX;
            sat_nxt   = 1'b1;
          end else begin
            inten_nxt = shq[49:0];
          end
          k_nxt     = '0;
          state_nxt = P_UDIV_GO;
        end
      end
      P_UDIV_GO: begin
        state_nxt = P_UDIV;
      end
      P_UDIV: begin
        if (div_done) begin
          // unit component never exceeds 2^30
          u_nxt     = div_quo[30:0];
          state_nxt = P_MLO;
        end
      end
      P_MLO: begin
        plo_nxt   = inten_r[23:0] * u_r;
        state_nxt = P_MHI;
      end
      P_MHI: begin
        phi_nxt   = inten_r[49:24] * u_r;
        state_nxt = P_COMB;
      end
      P_COMB: begin
        contrib_nxt[k_r] = neg_r[k_r] ? 52'(-{1'b0, c}) : {1'b0, c};
        k_nxt            = k_r + 2'd1;
        state_nxt        = (k_r == 2'd2) ? P_DONE : P_UDIV_GO;
      end
      P_DONE: begin
        state_nxt = P_IDLE;
      end
      default: begin
        state_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    str_r     <= str_nxt;
    e_r       <= e_nxt;
    s_r       <= s_nxt;
    k_r       <= k_nxt;
    q_r       <= q_nxt;
    n_r       <= n_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    sq_cnt_r  <= sq_cnt_nxt;
    r_r       <= r_nxt;
    inten_r   <= inten_nxt;
    u_r       <= u_nxt;
    plo_r     <= plo_nxt;
    phi_r     <= phi_nxt;
    contrib_r <= contrib_nxt;
    skip_r    <= skip_nxt;
    sat_r     <= sat_nxt;
  end

  assign done      = (state_r == P_DONE);
  assign pull.cx   = contrib_r[0];
  assign pull.cy   = contrib_r[1];
  assign pull.cz   = contrib_r[2];
  assign pull.skip = skip_r;
  assign pull.sat  = sat_r;

endmodule

// ===== sv/point_gravity_accumulator_core.sv =====
`timescale 1ns / 1ps
// Top level: attractor table, body sequencing, accumulation and output register.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall   | in_item_t
//  out_    | output    | out_valid / out_stall | out_item_t
//  cfg     | input     | psel/penable/pready   | attractor_count at byte 0
//
// A load item is written to the table on acceptance and leaves the core idle. A compute
// item holds in_stall from its acceptance until its result goes to the output register;
// the shared 56-step divider runs four times per summed attractor, except for an
// attractor sitting on the body. The finish state waits while the output register is full.
// Reset is synchronous (rst_n low); the table is not cleared and holds garbage
// until loaded. A finished result waits in the output register under out_stall
// while the next item is already accepted.
module point_gravity_accumulator_core
  import pga_pkg::*;
#(
  parameter int MAX_ATTRACTORS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
  localparam int IW    = $clog2(MAX_ATTRACTORS + 1);
  localparam int ACC_W = 53 + $clog2(MAX_ATTRACTORS + 1);

  localparam logic [2:0] C_IDLE   = 3'd0;
  localparam logic [2:0] C_READ   = 3'd1;
  localparam logic [2:0] C_START  = 3'd2;
  localparam logic [2:0] C_RUN    = 3'd3;
  localparam logic [2:0] C_FINISH = 3'd4;

  function automatic logic signed [47:0] clamp48(input logic signed [ACC_W-1:0] v,
                                                 output logic ovf);
    logic signed [47:0] r;
    ovf = (v[ACC_W-1:47] != '0) && (v[ACC_W-1:47] != '1);
    if (!ovf) r = v[47:0];
    else if (v[ACC_W-1]) r = {1'b1, 47'd0};
    else r = {1'b0, {47{1'b1}}};
    return r;
  endfunction

  logic [2:0]               state_r, state_nxt;
  logic [4:0]               count_r, count_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [IW-1:0]            n_r, n_nxt;
  logic signed [31:0]       body_x_r, body_x_nxt;
  logic signed [31:0]       body_y_r, body_y_nxt;
  logic signed [31:0]       body_z_r, body_z_nxt;
  logic signed [ACC_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic                     coinc_r, coinc_nxt;
  logic                     sat_r, sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     in_acc;
  logic                     out_free;
  logic                     cfg_wr;
  logic                     ram_we;
  logic                     ram_re;
  logic [127:0]             ram_rdata;
  logic                     pull_done;
  pull_t                    pull;
  logic                     ovx, ovy, ovz;
  logic signed [47:0]       cx48, cy48, cz48;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_COUNT);
  assign ram_we   = in_acc && (in_data.opcode == OP_LOAD) &&
                    (32'(in_data.slot) < MAX_ATTRACTORS);
  assign ram_re   = (state_r == C_READ);

  pga_ram #(
    .WIDTH (128),
    .DEPTH (MAX_ATTRACTORS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.slot)),
    .wdata ({in_data.strength, in_data.pos_z, in_data.pos_y, in_data.pos_x}),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  pga_pair u_pair (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == C_START),
    .att_x   (ram_rdata[31:0]),
    .att_y   (ram_rdata[63:32]),
    .att_z   (ram_rdata[95:64]),
    .att_str (ram_rdata[127:96]),
    .body_x  (body_x_r),
    .body_y  (body_y_r),
    .body_z  (body_z_r),
    .done    (pull_done),
    .pull    (pull)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cfg_wr ? pwdata[4:0] : count_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    body_x_nxt    = body_x_r;
    body_y_nxt    = body_y_r;
    body_z_nxt    = body_z_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    coinc_nxt     = coinc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cx48          = clamp48(ax_r, ovx);
    cy48          = clamp48(ay_r, ovy);
    cz48          = clamp48(az_r, ovz);

    case (state_r)
      C_IDLE: begin
        if (in_acc && (in_data.opcode == OP_COMPUTE)) begin
          body_x_nxt = in_data.pos_x;
          body_y_nxt = in_data.pos_y;
          body_z_nxt = in_data.pos_z;
          ax_nxt     = ACC_W'(in_data.accel_in_x);
          ay_nxt     = ACC_W'(in_data.accel_in_y);
          az_nxt     = ACC_W'(in_data.accel_in_z);
          coinc_nxt  = 1'b0;
          sat_nxt    = 1'b0;
          idx_nxt    = '0;
          n_nxt      = (32'(count_r) > MAX_ATTRACTORS) ? IW'(MAX_ATTRACTORS)
                                                      : IW'(count_r);
          state_nxt  = (n_nxt == '0) ? C_FINISH : C_READ;
        end
      end
      C_READ: begin
        state_nxt = C_START;
      end
      C_START: begin
        state_nxt = C_RUN;
      end
      C_RUN: begin
        if (pull_done) begin
          ax_nxt    = ax_r + {{(ACC_W-52){pull.cx[51]}}, pull.cx};
          ay_nxt    = ay_r + {{(ACC_W-52){pull.cy[51]}}, pull.cy};
          az_nxt    = az_r + {{(ACC_W-52){pull.cz[51]}}, pull.cz};
          coinc_nxt = coinc_r | pull.skip;
          sat_nxt   = sat_r | pull.sat;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_nxt == n_r) ? C_FINISH : C_READ;
        end
      end
      C_FINISH: begin
        if (out_free) begin
          out_data_nxt.accel_out_x = cx48;
          out_data_nxt.accel_out_y = cy48;
          out_data_nxt.accel_out_z = cz48;
          out_data_nxt.coincident  = coinc_r;
          out_data_nxt.saturated   = sat_r | ovx | ovy | ovz;
          out_valid_nxt            = 1'b1;
          state_nxt                = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
    end
    body_x_r   <= body_x_nxt;
    body_y_r   <= body_y_nxt;
    body_z_r   <= body_z_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    az_r       <= az_nxt;
    coinc_r    <= coinc_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != C_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign prdata    = 32'(count_r);
  assign pready    = 1'b1;

`ifndef ASSERT_OFF
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pull_done |-> state_r == C_RUN)
    else $error("pull finished outside the run state");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_READ || state_r == C_START || state_r == C_RUN) |-> idx_r < n_r)
    else $error("table index beyond the summed count");

  a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_RUN && pull_done) |=> (state_r == C_READ || state_r == C_FINISH))
    else $error("sequencer lost after a pull");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_FINISH && out_free) |=> (out_valid_r && state_r == C_IDLE))
    else $error("finished body not presented");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for point_gravity_accumulator_core: directed and random items, self-checking.
module tb_top;
  import pga_pkg::*;

  localparam int  TABLE_DEPTH = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
  localparam longint ACC_MIN = -(64'sd1 <<< 47);
  localparam longint unsigned PULL_MAX = (64'd1 << 50) - 1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  point_gravity_accumulator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [31:0] att_x [TABLE_DEPTH];
  logic signed [31:0] att_y [TABLE_DEPTH];
  logic signed [31:0] att_z [TABLE_DEPTH];
  logic [31:0]        att_str [TABLE_DEPTH];
  logic [4:0]         summed_count;

  out_item_t accel_q[$];
  int        n_fail;
  int        n_checked;
  int        n_coinc;
  int        n_sat;
  int        n_loads;
  int        n_bodies;
  bit        gaps_on;
  longint    cycles;

  function automatic longint unsigned isqrt50(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int b = 25; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic out_item_t attractor_pull(in_item_t it);
    out_item_t       res;
    longint          acc [3];
    longint          body [3];
    longint          d [3];
    longint unsigned mag [3];
    longint unsigned e [3];
    longint unsigned q, r, inten, u, hi, lo, ph, c;
    int              n, s;
    logic            coinc, sat;
    coinc = 1'b0;
    sat = 1'b0;
    body[0] = it.pos_x; body[1] = it.pos_y; body[2] = it.pos_z;
    acc[0] = it.accel_in_x; acc[1] = it.accel_in_y; acc[2] = it.accel_in_z;
    n = (summed_count > TABLE_DEPTH) ? TABLE_DEPTH : summed_count;
    for (int i = 0; i < n; i++) begin
      d[0] = longint'(att_x[i]) - body[0];
      d[1] = longint'(att_y[i]) - body[1];
      d[2] = longint'(att_z[i]) - body[2];
      for (int k = 0; k < 3; k++) mag[k] = (d[k] < 0) ? -d[k] : d[k];
      if ((mag[0] | mag[1] | mag[2]) == 0) begin
        coinc = 1'b1;
        continue;
      end
      s = 0;
      while (((mag[0] >> s) | (mag[1] >> s) | (mag[2] >> s)) >= (64'd1 << 24)) s++;
      q = 0;
      for (int k = 0; k < 3; k++) begin
        e[k] = mag[k] >> s;
        q += e[k] * e[k];
      end
      r = isqrt50(q);
      inten = ((longint'(att_str[i])) << 24) / q;
      inten = inten >> (2 * s);
      if (inten > PULL_MAX) begin
        inten = PULL_MAX;
        sat = 1'b1;
      end
      hi = inten >> 24;
      lo = inten & 64'hFFFFFF;
      for (int k = 0; k < 3; k++) begin
        u = (e[k] << 30) / r;
        ph = hi * u;
        c = (ph >> 6) + ((((ph & 64'd63) << 24) + lo * u) >> 30);
        if (d[k] < 0) acc[k] -= longint'(c);
        else acc[k] += longint'(c);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (acc[k] > ACC_MAX) begin
        acc[k] = ACC_MAX;
        sat = 1'b1;
      end else if (acc[k] < ACC_MIN) begin
        acc[k] = ACC_MIN;
        sat = 1'b1;
      end
    end
    res.accel_out_x = acc[0][47:0];
    res.accel_out_y = acc[1][47:0];
    res.accel_out_z = acc[2][47:0];
    res.coincident = coinc;
    res.saturated = sat;
    return res;
  endfunction

  // sends one item; valid stays high afterwards so back-to-back items need no toggle
  task automatic send_item(in_item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (it.opcode == OP_LOAD) begin
      att_x[it.slot] = it.pos_x;
      att_y[it.slot] = it.pos_y;
      att_z[it.slot] = it.pos_z;
      att_str[it.slot] = it.strength;
      n_loads++;
    end else begin
      accel_q.push_back(attractor_pull(it));
      n_bodies++;
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (accel_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [31:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_COUNT, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    summed_count = v[4:0];
  endtask

  function automatic in_item_t load_item(int slot, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [31:0] str);
    in_item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.slot = slot[3:0];
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.strength = str;
    it.accel_in_x = 48'({$urandom, $urandom});
    it.accel_in_y = 48'({$urandom, $urandom});
    it.accel_in_z = 48'({$urandom, $urandom});
    return it;
  endfunction

  function automatic in_item_t body_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic [47:0] ax, logic [47:0] ay, logic [47:0] az);
    in_item_t it;
    it.opcode = OP_COMPUTE;
    it.slot = 4'($urandom);
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.strength = $urandom;
    it.accel_in_x = ax; it.accel_in_y = ay; it.accel_in_z = az;
    return it;
  endfunction

  function automatic logic [47:0] rand_accel();
    case ($urandom_range(0, 5))
      0: return 48'h7FFF_FFFF_FFFF - $urandom_range(0, 1000);
      1: return 48'h8000_0000_0000 + $urandom_range(0, 1000);
      2: return {{16{1'b0}}, $urandom} >> $urandom_range(0, 31);
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // body placed on, near or far from a random attractor
  function automatic in_item_t rand_body();
    int          i;
    logic [31:0] p [3];
    i = $urandom_range(0, TABLE_DEPTH - 1);
    case ($urandom_range(0, 9))
      0: begin
        p[0] = att_x[i]; p[1] = att_y[i]; p[2] = att_z[i];
      end
      1, 2, 3, 4: begin
        p[0] = att_x[i] + $signed($urandom_range(0, 64)) - 32;
        p[1] = att_y[i] + $signed($urandom_range(0, 64)) - 32;
        p[2] = att_z[i] + ($urandom >> $urandom_range(0, 31));
      end
      5, 6: begin
        p[0] = att_x[i] + ($urandom >> $urandom_range(8, 31));
        p[1] = att_y[i] - ($urandom >> $urandom_range(8, 31));
        p[2] = att_z[i] + ($urandom >> $urandom_range(8, 31));
      end
      default: begin
        p[0] = $urandom; p[1] = $urandom; p[2] = $urandom;
      end
    endcase
    return body_item(p[0], p[1], p[2], rand_accel(), rand_accel(), rand_accel());
  endfunction

  function automatic in_item_t rand_load();
    logic [31:0] str;
    case ($urandom_range(0, 3))
      0: str = $urandom >> $urandom_range(0, 31);
      1: str = 32'hFFFF_FFFF;
      default: str = $urandom;
    endcase
    if ($urandom_range(0, 1))
      return load_item($urandom_range(0, 15), $urandom, $urandom, $urandom, str);
    return load_item($urandom_range(0, 15), $urandom >> 12, $urandom >> 12,
                     $urandom >> 12, str);
  endfunction

  // result side: stall drawn per result
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) stall_left <= gaps_on ? $urandom_range(0, 18) : 0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (accel_q.size() == 0) begin
        $error("result with nothing expected");
        n_fail++;
      end else begin
        want = accel_q.pop_front();
        n_checked++;
        if (want.coincident) n_coinc++;
        if (want.saturated) n_sat++;
        if (out_data.accel_out_x !== want.accel_out_x) begin
          $error("accel_out_x exp %h got %h", want.accel_out_x, out_data.accel_out_x);
          n_fail++;
        end
        if (out_data.accel_out_y !== want.accel_out_y) begin
          $error("accel_out_y exp %h got %h", want.accel_out_y, out_data.accel_out_y);
          n_fail++;
        end
        if (out_data.accel_out_z !== want.accel_out_z) begin
          $error("accel_out_z exp %h got %h", want.accel_out_z, out_data.accel_out_z);
          n_fail++;
        end
        if (out_data.coincident !== want.coincident) begin
          $error("coincident exp %b got %b", want.coincident, out_data.coincident);
          n_fail++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated exp %b got %b", want.saturated, out_data.saturated);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // every slot is written before any body can read it
  task automatic test_table_fill;
    in_item_t it;
    gaps_on = 1'b1;
    send_item(load_item(0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
    send_item(load_item(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
    send_item(load_item(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1));
    for (int i = 3; i < TABLE_DEPTH; i++) begin
      it = rand_load();
      it.slot = i[3:0];
      send_item(it);
    end
  endtask

  task automatic test_corner_bodies;
    write_count(32'd0);
    // nothing summed: acceleration passes through
    send_item(body_item(32'd5, 32'd6, 32'd7, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd0));
    write_count(32'd1);
    // body on the attractor is skipped
    send_item(body_item(32'd0, 32'd0, 32'd0, 48'h1234, 48'h0, 48'hFFFF_FFFF_FFFF));
    // one LSB away with full strength: pull clamps
    send_item(body_item(32'd1, 32'd0, 32'd0, 48'd0, 48'd0, 48'd0));
    send_item(body_item(32'd0, 32'hFFFF_FFFF, 32'd0, 48'h7FFF_FFFF_FFFF, 48'd0, 48'd0));
    send_item(body_item(32'd3, 32'd4, 32'd0, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'd7));
    write_count(32'd3);
    // widest separations to the extreme attractors
    send_item(body_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        48'd0, 48'd0, 48'd0));
    send_item(body_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd1));
    send_item(body_item(32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0100,
                        48'hFFFF_FFFF_FFFF, 48'd0, 48'd0));
    write_count(32'd16);
    send_item(rand_body());
    send_item(body_item(32'd0, 32'd0, 32'd0, rand_accel(), rand_accel(), rand_accel()));
    write_count(32'd31);
    send_item(rand_body());
    write_count(32'd17);
    send_item(rand_body());
  endtask

  task automatic test_random_mix(int count, int items);
    write_count(count);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 9) < 3) send_item(rand_load());
      else send_item(rand_body());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cycles = 0;
    n_fail = 0;
    n_checked = 0;
    n_coinc = 0;
    n_sat = 0;
    n_loads = 0;
    n_bodies = 0;
    gaps_on = 1'b0;
    summed_count = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_corner_bodies();
    test_random_mix(2, 70);
    test_random_mix(1, 70);
    test_random_mix(3, 60);
    test_random_mix(0, 40);
    test_random_mix(2, 70);
    test_random_mix(4, 50);
    test_random_mix(16, 25);
    test_random_mix(31, 10);
    drain();

    $display("%0d loads and %0d bodies sent, %0d results checked", n_loads, n_bodies,
             n_checked);
    $display("%0d results with a skipped attractor, %0d clamped", n_coinc, n_sat);
    if (n_fail == 0 && accel_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
